// ===== rtl/core/srwr_pkg.sv =====
// Shared types and codes for the secret region wipe registry.
// No dependencies; the other RTL files but srwr_ram refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps
`default_nettype none
package srwr_pkg;
	localparam int SLOT_COUNT  = 64;
	localparam int LENGTH_BITS = 48;
	localparam int ADDR_BITS   = 64;
	localparam int WORD_BITS   = 32;
	localparam int IDX_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W       = $clog2(SLOT_COUNT + 1);

	localparam logic [1:0] CMD_REGISTER   = 2'd0;
	localparam logic [1:0] CMD_UNREGISTER = 2'd1;
	localparam logic [1:0] CMD_FAULT      = 2'd2;

	localparam logic [1:0] COND_FREE   = 2'd0;
	localparam logic [1:0] COND_READY  = 2'd2;
	localparam logic [1:0] COND_WIPING = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_INVALID   = 3'd1;
	localparam logic [2:0] ST_ALREADY   = 3'd2;
	localparam logic [2:0] ST_BUSY      = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND = 3'd5;
	localparam logic [2:0] ST_HANDLED   = 3'd6;

	typedef struct packed {
		logic [1:0]             cond;
		logic [ADDR_BITS-1:0]   addr;
		logic [LENGTH_BITS-1:0] len;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef struct packed {
		logic [2:0]                  status;
		logic                        wipe_valid;
		logic [ADDR_BITS-1:0]        wipe_address;
		logic [LENGTH_BITS-1:0]      wipe_size;
		logic [WORD_BITS-1:0]        fault_site;
		logic signed [WORD_BITS-1:0] fault_errno;
		logic                        last;
	} res_t;
endpackage
`default_nettype wire

// ===== rtl/core/srwr_req_if.sv =====
// Command channel of the registry: valid/ready plus one command item.
// Depends on srwr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface srwr_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            cmd;
	logic [srwr_pkg::ADDR_BITS-1:0]        region_address;
	logic [srwr_pkg::LENGTH_BITS-1:0]      region_size;
	logic [srwr_pkg::WORD_BITS-1:0]        fault_site_in;
	logic signed [srwr_pkg::WORD_BITS-1:0] fault_errno_in;

	modport source (output valid, cmd, region_address, region_size, fault_site_in,
		fault_errno_in, input ready);
	modport sink (input valid, cmd, region_address, region_size, fault_site_in,
		fault_errno_in, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/srwr_rsp_if.sv =====
// Result channel of the registry: valid/ready plus one result item.
// Depends on srwr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface srwr_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic [2:0]                            status;
	logic                                  wipe_valid;
	logic [srwr_pkg::ADDR_BITS-1:0]        wipe_address;
	logic [srwr_pkg::LENGTH_BITS-1:0]      wipe_size;
	logic [srwr_pkg::WORD_BITS-1:0]        fault_site_out;
	logic signed [srwr_pkg::WORD_BITS-1:0] fault_errno_out;
	logic                                  last;

	modport source (output valid, status, wipe_valid, wipe_address, wipe_size,
		fault_site_out, fault_errno_out, last, input ready);
	modport sink (input valid, status, wipe_valid, wipe_address, wipe_size,
		fault_site_out, fault_errno_out, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/srwr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module srwr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [AW-1:0]            wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [AW-1:0]            rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/srwr_out.sv =====
// Output register of the registry: holds one result until the sink takes it.
// Depends on srwr_pkg and srwr_rsp_if.
`timescale 1ns / 1ps
`default_nettype none
module srwr_out (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire srwr_pkg::res_t  res,
	output      logic            out_free,
	srwr_rsp_if.source           rsp
);
	logic           valid_q;
	srwr_pkg::res_t res_q;

	assign out_free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign rsp.valid           = valid_q;
	assign rsp.status          = res_q.status;
	assign rsp.wipe_valid      = res_q.wipe_valid;
	assign rsp.wipe_address    = res_q.wipe_address;
	assign rsp.wipe_size       = res_q.wipe_size;
	assign rsp.fault_site_out  = res_q.fault_site;
	assign rsp.fault_errno_out = res_q.fault_errno;
	assign rsp.last            = res_q.last;
endmodule
`default_nettype wire

// ===== rtl/core/srwr_scan.sv =====
// Command sequencer: walks the slot memory at most once per command, read-modify-write.
// Depends on srwr_pkg and srwr_req_if; drives the slot RAM and the output register.
`timescale 1ns / 1ps
`default_nettype none
module srwr_scan (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	srwr_req_if.sink                           req,
	output      logic                          rd_en,
	output      logic [srwr_pkg::IDX_W-1:0]    rd_addr,
	input  wire logic [srwr_pkg::SLOT_W-1:0]   rd_data,
	output      logic                          wr_en,
	output      logic [srwr_pkg::IDX_W-1:0]    wr_addr,
	output      logic [srwr_pkg::SLOT_W-1:0]   wr_data,
	output      logic                          push,
	output      srwr_pkg::res_t                res,
	input  wire logic                          out_free
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	localparam logic [srwr_pkg::CNT_W-1:0] CNT_END = srwr_pkg::CNT_W'(srwr_pkg::SLOT_COUNT);

	logic [1:0]                            state_q;
	logic [srwr_pkg::CNT_W-1:0]            iss_q;
	logic                                  v_s1;
	logic [srwr_pkg::IDX_W-1:0]            idx_s1;
	logic                                  free_found_q;
	logic [srwr_pkg::IDX_W-1:0]            free_idx_q;
	logic                                  hold_v_q;
	logic [srwr_pkg::ADDR_BITS-1:0]        hold_addr_q;
	logic [srwr_pkg::LENGTH_BITS-1:0]      hold_len_q;
	logic                                  hook_q;
	logic                                  fault_latched_q;
	logic [srwr_pkg::SLOT_COUNT-1:0]       valid_q;
	logic [2:0]                            status_q;
	logic [1:0]                            cmd_q;
	logic [srwr_pkg::ADDR_BITS-1:0]        addr_q;
	logic [srwr_pkg::LENGTH_BITS-1:0]      size_q;
	logic [srwr_pkg::WORD_BITS-1:0]        site_q;
	logic signed [srwr_pkg::WORD_BITS-1:0] errno_q;

	srwr_pkg::slot_t slot;
	logic [1:0]      cond;
	logic            hit;
	logic            in_scan;
	logic            eval;
	logic            ready_hit;
	logic            stall;
	logic            abort;
	logic            adv;
	logic            scan_end;
	logic            accept;
	logic            scan_push;
	logic            resp_push;
	logic            fin_write;

	assign slot     = srwr_pkg::slot_t'(rd_data);
	assign cond     = valid_q[idx_s1] ? slot.cond : srwr_pkg::COND_FREE;
	assign hit      = (cond == srwr_pkg::COND_READY || cond == srwr_pkg::COND_WIPING)
		&& slot.addr == addr_q;
	assign in_scan  = state_q == S_SCAN;
	assign eval     = in_scan && v_s1;
	assign ready_hit = eval && cmd_q == srwr_pkg::CMD_FAULT && cond == srwr_pkg::COND_READY;
	assign stall    = ready_hit && hold_v_q && !out_free;
	assign abort    = eval && cmd_q != srwr_pkg::CMD_FAULT && hit;
	assign adv      = in_scan && !stall && !abort;
	assign scan_end = in_scan && !v_s1 && iss_q == CNT_END;
	assign accept   = req.valid && req.ready;

	assign req.ready = state_q == S_IDLE;

	assign rd_en   = adv && iss_q < CNT_END;
	assign rd_addr = iss_q[srwr_pkg::IDX_W-1:0];

	assign fin_write = scan_end && cmd_q == srwr_pkg::CMD_REGISTER && free_found_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = {srwr_pkg::COND_WIPING, slot.addr, slot.len};
		if (ready_hit && !stall) begin
			wr_en = 1'b1;
		end else if (fin_write) begin
			wr_en   = 1'b1;
			wr_addr = free_idx_q;
			wr_data = {srwr_pkg::COND_READY, addr_q, size_q};
		end
	end

	assign scan_push = ready_hit && hold_v_q && out_free;
	assign resp_push = state_q == S_RESP && out_free;
	assign push      = scan_push || resp_push;

	always_comb begin
		if (scan_push) begin
			res.status       = srwr_pkg::ST_OK;
			res.wipe_valid   = 1'b1;
			res.wipe_address = hold_addr_q;
			res.wipe_size    = hold_len_q;
			res.fault_site   = site_q;
			res.fault_errno  = errno_q;
			res.last         = 1'b0;
		end else begin
			res.status       = status_q;
			res.wipe_valid   = hold_v_q;
			res.wipe_address = hold_v_q ? hold_addr_q : '0;
			res.wipe_size    = hold_v_q ? hold_len_q : '0;
			res.fault_site   = hook_q ? site_q : '0;
			res.fault_errno  = hook_q ? errno_q : '0;
			res.last         = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			iss_q           <= '0;
			v_s1            <= 1'b0;
			free_found_q    <= 1'b0;
			hold_v_q        <= 1'b0;
			hook_q          <= 1'b0;
			fault_latched_q <= 1'b0;
			valid_q         <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						iss_q        <= '0;
						v_s1         <= 1'b0;
						free_found_q <= 1'b0;
						hold_v_q     <= 1'b0;
						hook_q       <= 1'b0;
						unique case (req.cmd)
							srwr_pkg::CMD_REGISTER: begin
								state_q <= (req.region_address == '0 || req.region_size == '0)
									? S_RESP : S_SCAN;
							end
							srwr_pkg::CMD_UNREGISTER: begin
								state_q <= (req.region_address == '0) ? S_RESP : S_SCAN;
							end
							srwr_pkg::CMD_FAULT: begin
								state_q <= fault_latched_q ? S_RESP : S_SCAN;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (adv) begin
						if (rd_en) begin
							iss_q <= iss_q + srwr_pkg::CNT_W'(1);
							v_s1  <= 1'b1;
						end else begin
							v_s1 <= 1'b0;
						end
					end
					if (eval && !stall && !abort) begin
						if (cmd_q == srwr_pkg::CMD_REGISTER && cond == srwr_pkg::COND_FREE
							&& !free_found_q) begin
							free_found_q <= 1'b1;
						end
						if (ready_hit) begin
							hold_v_q <= 1'b1;
						end
					end
					if (abort) begin
						v_s1    <= 1'b0;
						state_q <= S_RESP;
						if (cmd_q == srwr_pkg::CMD_UNREGISTER && cond == srwr_pkg::COND_READY) begin
							valid_q[idx_s1] <= 1'b0;
						end
					end
					if (scan_end) begin
						state_q <= S_RESP;
						if (fin_write) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						if (cmd_q == srwr_pkg::CMD_FAULT) begin
							fault_latched_q <= 1'b1;
							hook_q          <= 1'b1;
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q  <= S_IDLE;
						hold_v_q <= 1'b0;
						hook_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.cmd;
			addr_q  <= req.region_address;
			size_q  <= req.region_size;
			site_q  <= req.fault_site_in;
			errno_q <= req.fault_errno_in;
			priority if (req.cmd == srwr_pkg::CMD_FAULT && fault_latched_q) begin
				status_q <= srwr_pkg::ST_HANDLED;
			end else begin
				status_q <= srwr_pkg::ST_INVALID;
			end
		end
		if (adv && rd_en) begin
			idx_s1 <= iss_q[srwr_pkg::IDX_W-1:0];
		end
		if (eval && !stall && !abort && cmd_q == srwr_pkg::CMD_REGISTER
			&& cond == srwr_pkg::COND_FREE && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
		if (ready_hit && !stall) begin
			hold_addr_q <= slot.addr;
			hold_len_q  <= slot.len;
		end
		if (abort) begin
			priority if (cond == srwr_pkg::COND_WIPING) begin
				status_q <= srwr_pkg::ST_BUSY;
			end else if (cmd_q == srwr_pkg::CMD_REGISTER) begin
				status_q <= srwr_pkg::ST_ALREADY;
			end else begin
				status_q <= srwr_pkg::ST_OK;
			end
		end
		if (scan_end) begin
			priority if (cmd_q == srwr_pkg::CMD_FAULT) begin
				status_q <= srwr_pkg::ST_OK;
			end else if (cmd_q == srwr_pkg::CMD_UNREGISTER) begin
				status_q <= srwr_pkg::ST_NOT_FOUND;
			end else if (free_found_q) begin
				status_q <= srwr_pkg::ST_OK;
			end else begin
				status_q <= srwr_pkg::ST_FULL;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/secret_region_wipe_registry.sv =====
// Channel | dir | carries
// req     | in  | cmd, region_address, region_size, fault_site_in, fault_errno_in
// rsp     | out | status, wipe_valid, wipe_address, wipe_size, fault_site_out,
//         |     | fault_errno_out, last
// One command at a time; a command walks the slot RAM at most once, one slot read per
// cycle while no full rsp stalls a fault; a hit on register or unregister ends the walk.
// The next command is taken once the final result has been pushed to the output register.
// Invalid codes, zero address or size, and repeated faults skip the walk and go
// straight to the final result.
// A full rsp holds the walk at each later ready slot of a fault and holds the final result.
// Reset clears slot valid bits and the fault latch at once; no clearing pass.
// Top level of the secret region wipe registry; depends on srwr_pkg, both
// channel interfaces, srwr_ram, srwr_scan and srwr_out.
`timescale 1ns / 1ps
`default_nettype none
module secret_region_wipe_registry (
	input  wire logic  clk,
	input  wire logic  arst_n,
	srwr_req_if.sink   req,
	srwr_rsp_if.source rsp
);
	logic                          rd_en;
	logic [srwr_pkg::IDX_W-1:0]    rd_addr;
	logic [srwr_pkg::SLOT_W-1:0]   rd_data;
	logic                          wr_en;
	logic [srwr_pkg::IDX_W-1:0]    wr_addr;
	logic [srwr_pkg::SLOT_W-1:0]   wr_data;
	logic                          push;
	srwr_pkg::res_t                res;
	logic                          out_free;

	srwr_ram #(
		.WIDTH (srwr_pkg::SLOT_W),
		.DEPTH (srwr_pkg::SLOT_COUNT)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	srwr_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.push     (push),
		.res      (res),
		.out_free (out_free)
	);

	srwr_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.res      (res),
		.out_free (out_free),
		.rsp      (rsp)
	);

`ifndef NO_ASSERTIONS
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("command accepted while another is in flight");

	a_wipe_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.wipe_valid |-> rsp.status == srwr_pkg::ST_OK)
		else $error("wipe transfer with non-ok status");

	a_nonlast_wipe: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.last |-> rsp.wipe_valid)
		else $error("non-final transfer without a region");
`endif
endmodule
`default_nettype wire

// ===== tb/srwr_checker.sv =====
// Checker for the secret region wipe registry: tracks the slot table from
// accepted commands and compares every accepted result with the expected one.
// Depends on srwr_pkg, srwr_req_if and srwr_rsp_if.
`timescale 1ns / 1ps
module srwr_checker (
	input  logic clk,
	input  logic arst_n,
	srwr_req_if  req,
	srwr_rsp_if  rsp,
	output int   mismatches,
	output int   outstanding
);
	import srwr_pkg::*;

	logic [1:0]             slot_cond [SLOT_COUNT];
	logic [ADDR_BITS-1:0]   slot_base [SLOT_COUNT];
	logic [LENGTH_BITS-1:0] slot_len  [SLOT_COUNT];
	logic                   fault_seen;
	res_t                   pending_replies [$];
	res_t                   want;
	int                     mismatch_cnt = 0;
	int                     pending_cnt = 0;

	assign mismatches  = mismatch_cnt;
	assign outstanding = pending_cnt;

	function automatic res_t make_reply(logic [2:0] st, logic wv, logic [ADDR_BITS-1:0] a,
		logic [LENGTH_BITS-1:0] s, logic [WORD_BITS-1:0] site,
		logic signed [WORD_BITS-1:0] err, logic fin);
		res_t r;
		r.status       = st;
		r.wipe_valid   = wv;
		r.wipe_address = a;
		r.wipe_size    = s;
		r.fault_site   = site;
		r.fault_errno  = err;
		r.last         = fin;
		return r;
	endfunction

	// Update the slot table for one command and queue the replies it causes.
	function automatic void run_command(logic [1:0] c, logic [ADDR_BITS-1:0] a,
		logic [LENGTH_BITS-1:0] s, logic [WORD_BITS-1:0] site,
		logic signed [WORD_BITS-1:0] err);
		logic [2:0] st;
		int hit;
		int free_idx;
		int ready_cnt;
		int k;
		st = ST_INVALID;
		hit = -1;
		free_idx = -1;
		ready_cnt = 0;
		k = 0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (slot_cond[i] != COND_FREE && slot_base[i] == a && hit < 0)
				hit = i;
			if (slot_cond[i] == COND_FREE && free_idx < 0)
				free_idx = i;
			if (slot_cond[i] == COND_READY)
				ready_cnt++;
		end
		case (c)
		CMD_REGISTER: begin
			if (a == '0 || s == '0)
				st = ST_INVALID;
			else if (hit >= 0)
				st = (slot_cond[hit] == COND_READY) ? ST_ALREADY : ST_BUSY;
			else if (free_idx < 0)
				st = ST_FULL;
			else begin
				slot_cond[free_idx] = COND_READY;
				slot_base[free_idx] = a;
				slot_len[free_idx]  = s;
				st = ST_OK;
			end
		end
		CMD_UNREGISTER: begin
			if (a == '0)
				st = ST_INVALID;
			else if (hit < 0)
				st = ST_NOT_FOUND;
			else if (slot_cond[hit] == COND_WIPING)
				st = ST_BUSY;
			else begin
				slot_cond[hit] = COND_FREE;
				slot_base[hit] = '0;
				slot_len[hit]  = '0;
				st = ST_OK;
			end
		end
		CMD_FAULT: begin
			if (fault_seen)
				st = ST_HANDLED;
			else begin
				fault_seen = 1'b1;
				if (ready_cnt == 0) begin
					pending_replies.push_back(make_reply(ST_OK, 1'b0, '0, '0, site, err, 1'b1));
					return;
				end
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (slot_cond[i] == COND_READY) begin
						slot_cond[i] = COND_WIPING;
						k++;
						pending_replies.push_back(make_reply(ST_OK, 1'b1, slot_base[i],
							slot_len[i], site, err, k == ready_cnt));
					end
				end
				return;
			end
		end
		default: begin
			st = ST_INVALID;
		end
		endcase
		pending_replies.push_back(make_reply(st, 1'b0, '0, '0, '0, '0, 1'b1));
	endfunction

	task automatic note_mismatch(input string what);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t mismatch: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_cond[i] = COND_FREE;
				slot_base[i] = '0;
				slot_len[i]  = '0;
			end
			fault_seen = 1'b0;
			pending_replies.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_replies.size() == 0) begin
					note_mismatch($sformatf("unexpected transfer st=%0d wv=%0d a=%h s=%h last=%0d",
						rsp.status, rsp.wipe_valid, rsp.wipe_address, rsp.wipe_size, rsp.last));
				end else begin
					want = pending_replies.pop_front();
					if (rsp.status !== want.status || rsp.wipe_valid !== want.wipe_valid ||
						rsp.wipe_address !== want.wipe_address ||
						rsp.wipe_size !== want.wipe_size ||
						rsp.fault_site_out !== want.fault_site ||
						rsp.fault_errno_out !== want.fault_errno || rsp.last !== want.last) begin
						note_mismatch($sformatf(
							"exp st=%0d wv=%0d a=%h s=%h site=%h err=%0d last=%0d",
							want.status, want.wipe_valid, want.wipe_address, want.wipe_size,
							want.fault_site, want.fault_errno, want.last));
						if (mismatch_cnt <= 10)
							$display("    got st=%0d wv=%0d a=%h s=%h site=%h err=%0d last=%0d",
								rsp.status, rsp.wipe_valid, rsp.wipe_address, rsp.wipe_size,
								rsp.fault_site_out, rsp.fault_errno_out, rsp.last);
					end
				end
			end
			if (req.valid && req.ready)
				run_command(req.cmd, req.region_address, req.region_size, req.fault_site_in,
					req.fault_errno_in);
		end
		pending_cnt = pending_replies.size();
	end
endmodule

// ===== tb/tb_top.sv =====
// Top of the registry testbench: clock, reset, command stimulus, result stalls
// and the verdict. Depends on srwr_pkg, both channel interfaces, the registry and srwr_checker.
`timescale 1ns / 1ps
module tb_top;
	import srwr_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int POOL_SIZE    = 96;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 100;

	logic                 clk;
	logic                 arst_n;
	int                   mismatches;
	int                   outstanding;
	int                   burst_left = 0;
	int                   quiet_cycles = 0;
	int                   ready_on;
	int                   ready_off;
	logic [ADDR_BITS-1:0] addr_pool [POOL_SIZE];

	srwr_req_if req_ch ();
	srwr_rsp_if rsp_ch ();

	secret_region_wipe_registry u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	srwr_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [LENGTH_BITS-1:0] rand_size();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 7))
		0: return LENGTH_BITS'(1);
		1: return '1;
		2: return LENGTH_BITS'(raw[15:0]) | LENGTH_BITS'(1);
		default: return (raw[LENGTH_BITS-1:0] == '0) ? LENGTH_BITS'(1) : raw[LENGTH_BITS-1:0];
		endcase
	endfunction

	// Hold valid until the transfer; open a new burst after a random gap.
	task automatic send_cmd(input logic [1:0] c, input logic [ADDR_BITS-1:0] a,
		input logic [LENGTH_BITS-1:0] s);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : $urandom_range(0, 6);
		end
		burst_left--;
		repeat (gap) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.cmd            <= c;
		req_ch.region_address <= a;
		req_ch.region_size    <= s;
		req_ch.fault_site_in  <= $urandom;
		req_ch.fault_errno_in <= $urandom;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_cmd(input bit with_faults);
		int pick;
		logic [ADDR_BITS-1:0] a;
		pick = $urandom_range(0, 99);
		a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (pick < 45)
			send_cmd(CMD_REGISTER, a, rand_size());
		else if (pick < 75)
			send_cmd(CMD_UNREGISTER, a, rand_size());
		else if (pick < 80)
			send_cmd(CMD_REGISTER, {$urandom, $urandom}, rand_size());
		else if (pick < 82)
			send_cmd(CMD_REGISTER, '0, rand_size());
		else if (pick < 84)
			send_cmd(CMD_REGISTER, a, '0);
		else if (pick < 86)
			send_cmd(CMD_UNREGISTER, '0, rand_size());
		else if (pick < 89)
			send_cmd(CMD_UNREGISTER, {$urandom, $urandom}, rand_size());
		else if (pick < 92)
			send_cmd(CMD_UNUSED, a, rand_size());
		else if (with_faults)
			send_cmd(CMD_FAULT, a, rand_size());
		else
			send_cmd(CMD_REGISTER, a, rand_size());
	endtask

	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			ready_on  = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 300 : 20);
			ready_off = $urandom_range(0, ($urandom_range(0, 5) == 0) ? 30 : 6);
			repeat (ready_on) begin
				@(negedge clk);
				rsp_ch.ready <= 1'b1;
			end
			repeat (ready_off) begin
				@(negedge clk);
				rsp_ch.ready <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		arst_n                = 1'b0;
		req_ch.valid          = 1'b0;
		req_ch.cmd            = CMD_REGISTER;
		req_ch.region_address = '0;
		req_ch.region_size    = '0;
		req_ch.fault_site_in  = '0;
		req_ch.fault_errno_in = '0;
		for (int i = 0; i < POOL_SIZE; i++) begin
			do
				addr_pool[i] = {$urandom, $urandom};
			while (addr_pool[i] == '0);
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_cmd(CMD_REGISTER, '0, LENGTH_BITS'(5));
		send_cmd(CMD_REGISTER, 64'h1234, '0);
		send_cmd(CMD_REGISTER, '1, '1);
		send_cmd(CMD_REGISTER, 64'd1, LENGTH_BITS'(1));
		send_cmd(CMD_REGISTER, '1, LENGTH_BITS'(7));
		send_cmd(CMD_UNREGISTER, '0, '1);
		send_cmd(CMD_UNREGISTER, 64'h8000_0000_0000_0000, '0);
		send_cmd(CMD_UNREGISTER, 64'd1, '0);
		send_cmd(CMD_UNREGISTER, 64'd1, '0);
		send_cmd(CMD_UNUSED, '1, '1);
		send_cmd(CMD_REGISTER, 64'd1, '1);
		send_cmd(CMD_REGISTER, 64'h8000_0000_0000_0000, 48'h8000_0000_0000);
		send_cmd(CMD_UNREGISTER, '1, '0);
		send_cmd(CMD_REGISTER, '1, LENGTH_BITS'(1));

		repeat (150) random_cmd(1'b0);
		// fill the table past its capacity
		for (int i = 0; i < POOL_SIZE; i++)
			send_cmd(CMD_REGISTER, addr_pool[i], rand_size());
		repeat (80) random_cmd(1'b0);
		send_cmd(CMD_FAULT, {$urandom, $urandom}, rand_size());
		repeat (140) random_cmd(1'b1);
		req_ch.valid <= 1'b0;

		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/srwr_pkg.sv
rtl/core/srwr_req_if.sv
rtl/core/srwr_rsp_if.sv
rtl/core/srwr_ram.sv
rtl/core/srwr_out.sv
rtl/core/srwr_scan.sv
rtl/core/secret_region_wipe_registry.sv
tb/srwr_checker.sv
tb/tb_top.sv
